@@ rtl/sbs8_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbs8_pkg
// Shared widths, sizes and coefficient tables of the eight-band synthesis
// filterbank.
// ----------------------------------------------------------------------------
package sbs8_pkg;

   localparam int RING_LENGTH = 160;
   localparam int RING_IDX_W  = 8;
   localparam int RING_AW     = RING_IDX_W + 1;
   localparam int RING_DEPTH  = 1 << RING_AW;
   localparam int OFF_W       = 8;
   localparam int OFF_AW      = 5;
   localparam int OFF_DEPTH   = 1 << OFF_AW;
   localparam int WORD_W      = 17;
   localparam int SUB_W       = 18;
   localparam int COEF_W      = 17;
   localparam int PCM_W       = 16;
   localparam int ACC_W       = 32;
   localparam int BANDS       = 8;
   localparam int ROWS        = 16;
   localparam int TAPS        = 10;
   localparam int COPY_WORDS  = 9;
   localparam int SHIFT       = 15;

   localparam logic signed [WORD_W-1:0] PCM_MAX = 17'sd32767;
   localparam logic signed [WORD_W-1:0] PCM_MIN = -17'sd32767;

   typedef logic signed [SUB_W-1:0]  sub_type;
   typedef logic signed [COEF_W-1:0] coef_type;

   localparam logic [31:0] MATRIX_COEF [ROWS*BANDS] = '{
      32'h0000B504,32'hFFFF4AFB,32'hFFFF4AFB,32'h0000B504,
      32'h0000B504,32'hFFFF4AFB,32'hFFFF4AFB,32'h0000B504,
      32'h00008E39,32'hFFFF04EB,32'h000031F1,32'h0000D4DB,
      32'hFFFF2B24,32'hFFFFCE0E,32'h0000FB14,32'hFFFF71C6,
      32'h000061F7,32'hFFFF137C,32'h0000EC83,32'hFFFF9E08,
      32'hFFFF9E08,32'h0000EC83,32'hFFFF137C,32'h000061F7,
      32'h000031F1,32'hFFFF71C6,32'h0000D4DB,32'hFFFF04EB,
      32'h0000FB14,32'hFFFF2B24,32'h00008E39,32'hFFFFCE0E,
      32'h00000000,32'h00000000,32'h00000000,32'h00000000,
      32'h00000000,32'h00000000,32'h00000000,32'h00000000,
      32'hFFFFCE0E,32'h00008E39,32'hFFFF2B24,32'h0000FB14,
      32'hFFFF04EB,32'h0000D4DB,32'hFFFF71C6,32'h000031F1,
      32'hFFFF9E08,32'h0000EC83,32'hFFFF137C,32'h000061F7,
      32'h000061F7,32'hFFFF137C,32'h0000EC83,32'hFFFF9E08,
      32'hFFFF71C6,32'h0000FB14,32'hFFFFCE0E,32'hFFFF2B24,
      32'h0000D4DB,32'h000031F1,32'hFFFF04EB,32'h00008E39,
      32'hFFFF4AFB,32'h0000B504,32'h0000B504,32'hFFFF4AFB,
      32'hFFFF4AFB,32'h0000B504,32'h0000B504,32'hFFFF4AFB,
      32'hFFFF2B24,32'h000031F1,32'h0000FB14,32'h00008E39,
      32'hFFFF71C6,32'hFFFF04EB,32'hFFFFCE0E,32'h0000D4DB,
      32'hFFFF137C,32'hFFFF9E08,32'h000061F7,32'h0000EC83,
      32'h0000EC83,32'h000061F7,32'hFFFF9E08,32'hFFFF137C,
      32'hFFFF04EB,32'hFFFF2B24,32'hFFFF71C6,32'hFFFFCE0E,
      32'h000031F1,32'h00008E39,32'h0000D4DB,32'h0000FB14,
      32'hFFFF0000,32'hFFFF0000,32'hFFFF0000,32'hFFFF0000,
      32'hFFFF0000,32'hFFFF0000,32'hFFFF0000,32'hFFFF0000,
      32'hFFFF04EB,32'hFFFF2B24,32'hFFFF71C6,32'hFFFFCE0E,
      32'h000031F1,32'h00008E39,32'h0000D4DB,32'h0000FB14,
      32'hFFFF137C,32'hFFFF9E08,32'h000061F7,32'h0000EC83,
      32'h0000EC83,32'h000061F7,32'hFFFF9E08,32'hFFFF137C,
      32'hFFFF2B24,32'h000031F1,32'h0000FB14,32'h00008E39,
      32'hFFFF71C6,32'hFFFF04EB,32'hFFFFCE0E,32'h0000D4DB
   };

   localparam logic [31:0] WINDOW_TAP [BANDS*TAPS] = '{
      32'h00000000,32'hFFFFFDF0,32'hFFFFFA34,32'hFFFFF2C0,32'hFFFFBA5E,
      32'hFFFF6984,32'h000045A1,32'hFFFFF2C0,32'h000005CB,32'hFFFFFDF0,
      32'hFFFFFFD6,32'hFFFFFDD8,32'hFFFFF7C7,32'hFFFFF6EE,32'hFFFFAB06,
      32'hFFFF6B1E,32'h00003676,32'hFFFFF050,32'h00000394,32'hFFFFFE2C,
      32'hFFFFFFA6,32'hFFFFFDF5,32'hFFFFF54A,32'hFFFFFD01,32'hFFFF9C15,
      32'hFFFF6FDE,32'h00002803,32'hFFFFEF63,32'h000001B0,32'hFFFFFE7C,
      32'hFFFFFF6E,32'hFFFFFE58,32'hFFFFF2F2,32'h00000508,32'hFFFF8E22,
      32'hFFFF7789,32'h00001ABC,32'hFFFFEFB6,32'h0000002E,32'hFFFFFED5,
      32'hFFFFFF28,32'hFFFFFF13,32'hFFFFF0FE,32'h00000EFD,32'hFFFF81C6,
      32'hFFFF81C6,32'h00000EFD,32'hFFFFF0FE,32'hFFFFFF13,32'hFFFFFF28,
      32'hFFFFFED5,32'h0000002E,32'hFFFFEFB6,32'h00001ABC,32'hFFFF7789,
      32'hFFFF8E22,32'h00000508,32'hFFFFF2F2,32'hFFFFFE58,32'hFFFFFF6E,
      32'hFFFFFE7C,32'h000001B0,32'hFFFFEF63,32'h00002803,32'hFFFF6FDE,
      32'hFFFF9C15,32'hFFFFFD01,32'hFFFFF54A,32'hFFFFFDF5,32'hFFFFFFA6,
      32'hFFFFFE2C,32'h00000394,32'hFFFFF050,32'h00003676,32'hFFFF6B1E,
      32'hFFFFAB06,32'hFFFFF6EE,32'hFFFFF7C7,32'hFFFFFDD8,32'hFFFFFFD6
   };

   // matrixing coefficient of one row and band
   function automatic coef_type matrix_coef(input logic [3:0] row, input logic [2:0] band);
      logic [31:0] w;
      w = MATRIX_COEF[{row, band}];
      return coef_type'(w[COEF_W-1:0]);
   endfunction

   // prototype window tap of one output sample
   function automatic coef_type window_tap(input logic [2:0] samp, input logic [3:0] tap);
      logic [6:0]  idx;
      logic [31:0] w;
      idx = {1'b0, samp, 3'b000} + {3'b000, samp, 1'b0} + {3'b000, tap};
      w   = WINDOW_TAP[idx];
      return coef_type'(w[COEF_W-1:0]);
   endfunction

endpackage

@@ rtl/sbs8_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbs8_if
// Request and response channels of the synthesis filterbank.
// ----------------------------------------------------------------------------
interface sbs8_req_if import sbs8_pkg::*; ();
   logic    valid;
   logic    ready;
   logic    channel;
   sub_type sub0;
   sub_type sub1;
   sub_type sub2;
   sub_type sub3;
   sub_type sub4;
   sub_type sub5;
   sub_type sub6;
   sub_type sub7;

   modport source (output valid, channel, sub0, sub1, sub2, sub3, sub4, sub5, sub6, sub7,
                   input ready);
   modport sink   (input valid, channel, sub0, sub1, sub2, sub3, sub4, sub5, sub6, sub7,
                   output ready);
endinterface

interface sbs8_rsp_if import sbs8_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic signed [PCM_W-1:0] pcm_sample;
   logic [2:0]              sample_index;
   logic                    last;

   modport source (output valid, pcm_sample, sample_index, last, input ready);
   modport sink   (input valid, pcm_sample, sample_index, last, output ready);
endinterface

@@ rtl/sbs8_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbs8_ram
// Generic simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module sbs8_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

@@ rtl/subband_synthesis_8_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// subband_synthesis_8_core
// Eight-band synthesis filterbank: 16-row matrixing into a per-channel
// history ring, then a ten-tap window per output with clipping.
// ----------------------------------------------------------------------------
//  channel | dir | payload                                  | handshake
//  req     | in  | channel, sub0..sub7 (18-bit signed)      | valid/ready
//  rsp     | out | pcm_sample, sample_index, last           | valid/ready
//
//  A request runs 16 rows of matrixing on the shared multiply-accumulate
//  unit, then 8 window outputs; a row that reloads its phase offset adds
//  the nine-word wrap copy. After reset a clearing pass zeroes the history
//  RAM and loads the phase offsets; no request is taken meanwhile.
//  One request at a time; a stalled response holds the output register and
//  stops the sequencer before the next sample.
// ----------------------------------------------------------------------------
module subband_synthesis_8_core import sbs8_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   sbs8_req_if.sink    req,
   sbs8_rsp_if.source  rsp
);

   localparam logic [3:0] S_CLR  = 4'd0;
   localparam logic [3:0] S_IDLE = 4'd1;
   localparam logic [3:0] S_ORD  = 4'd2;
   localparam logic [3:0] S_OCHK = 4'd3;
   localparam logic [3:0] S_CPY  = 4'd4;
   localparam logic [3:0] S_MAC  = 4'd5;
   localparam logic [3:0] S_MDRN = 4'd6;
   localparam logic [3:0] S_WRA  = 4'd7;
   localparam logic [3:0] S_WRB  = 4'd8;
   localparam logic [3:0] S_WGB  = 4'd9;
   localparam logic [3:0] S_WMAC = 4'd10;
   localparam logic [3:0] S_WDRN = 4'd11;
   localparam logic [3:0] S_WOUT = 4'd12;

   logic [3:0]              state_ff, state_in;
   logic [RING_AW-1:0]      cnt_ff, cnt_in;
   logic [3:0]              row_ff, row_in;
   logic [2:0]              samp_ff, samp_in;
   logic                    ch_ff;
   sub_type                 sub_ff [BANDS];
   logic [OFF_W-1:0]        off_new_ff, a_ff, b_ff;
   logic                    s1_vld_ff;
   logic [3:0]              s1_idx_ff;
   logic                    p_vld_ff;
   logic [ACC_W-1:0]        prod_ff, acc_ff;
   logic                    rsp_vld_ff;
   logic signed [PCM_W-1:0] pcm_ff;
   logic [2:0]              idx_ff;
   logic                    last_ff;

   logic                    ring_we;
   logic [RING_AW-1:0]      ring_wa, ring_ra;
   logic [WORD_W-1:0]       ring_wd, ring_rd;
   logic                    off_we;
   logic [OFF_AW-1:0]       off_wa, off_ra;
   logic [OFF_W-1:0]        off_wd, off_rd, off_next;
   logic                    issue, drained, win_mode, rsp_load, req_acc;
   logic signed [SUB_W-1:0] mul_a;
   coef_type                mul_b;
   logic signed [SUB_W+COEF_W-1:0] mul_p;
   logic [RING_IDX_W-1:0]   tap_base, copy_dst;
   logic [OFF_W-1:0]        clr_off;
   logic signed [WORD_W-1:0] scaled;
   logic signed [PCM_W-1:0] clipped;

   sbs8_ram #(.WIDTH(WORD_W), .DEPTH(RING_DEPTH)) u_ring (
      .clock   (clock),
      .wr_en   (ring_we),
      .wr_addr (ring_wa),
      .wr_data (ring_wd),
      .rd_addr (ring_ra),
      .rd_data (ring_rd)
   );

   sbs8_ram #(.WIDTH(OFF_W), .DEPTH(OFF_DEPTH)) u_offs (
      .clock   (clock),
      .wr_en   (off_we),
      .wr_addr (off_wa),
      .wr_data (off_wd),
      .rd_addr (off_ra),
      .rd_data (off_rd)
   );

   assign req.ready = (state_ff == S_IDLE);
   assign req_acc   = req.valid && req.ready;
   assign drained   = !s1_vld_ff && !p_vld_ff;
   assign win_mode  = (state_ff == S_WMAC) || (state_ff == S_WDRN);
   assign rsp_load  = (state_ff == S_WOUT) && (!rsp_vld_ff || rsp.ready);

   // offset countdown with reload at zero
   assign off_next = (off_rd == '0) ? OFF_W'(RING_LENGTH - 1) : off_rd - 1'b1;
   // reset value of the offset being cleared: (row + 1) * 10
   assign clr_off  = ({4'b0000, cnt_ff[3:0]} + 1'b1) * 8'd10;
   assign copy_dst = RING_IDX_W'(RING_LENGTH - 1) + cnt_ff[RING_IDX_W-1:0];
   // even taps from the offset of row samp, odd taps from one past that of row samp + 8
   assign tap_base = (cnt_ff[0] ? b_ff : a_ff) + {4'b0000, cnt_ff[3:1], 1'b0};

   // history ring access
   always_comb begin
      ring_we = 1'b0;
      ring_wa = {ch_ff, off_new_ff};
      ring_wd = acc_ff[SHIFT +: WORD_W];
      ring_ra = {ch_ff, tap_base};
      unique case (state_ff)
         S_CLR: begin
            ring_we = 1'b1;
            ring_wa = cnt_ff;
            ring_wd = '0;
         end
         S_CPY: begin
            ring_we = (cnt_ff != '0);
            ring_wa = {ch_ff, copy_dst};
            ring_wd = ring_rd;
            ring_ra = {ch_ff, cnt_ff[RING_IDX_W-1:0]};
         end
         S_MDRN: begin
            ring_we = drained;
         end
         default: begin
         end
      endcase
   end

   // phase offset access
   always_comb begin
      off_we = 1'b0;
      off_wa = {ch_ff, row_ff};
      off_wd = off_next;
      off_ra = {ch_ff, row_ff};
      unique case (state_ff)
         S_CLR: begin
            off_we = (cnt_ff[RING_AW-1:OFF_AW] == '0);
            off_wa = cnt_ff[OFF_AW-1:0];
            off_wd = clr_off;
         end
         S_OCHK:  off_we = 1'b1;
         S_WRA:   off_ra = {ch_ff, 1'b0, samp_ff};
         S_WRB:   off_ra = {ch_ff, 1'b1, samp_ff};
         default: begin
         end
      endcase
   end

   // shared multiplier operands
   always_comb begin
      if (win_mode) begin
         mul_a = {ring_rd[WORD_W-1], ring_rd};
         mul_b = window_tap(samp_ff, s1_idx_ff);
      end else begin
         mul_a = sub_ff[s1_idx_ff[2:0]];
         mul_b = matrix_coef(row_ff, s1_idx_ff[2:0]);
      end
   end
   assign mul_p = mul_a * mul_b;

   // sequencer
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      row_in   = row_ff;
      samp_in  = samp_ff;
      issue    = 1'b0;
      unique case (state_ff)
         S_CLR: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == RING_AW'(RING_DEPTH - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_acc) begin
               state_in = S_ORD;
               row_in   = '0;
            end
         end
         S_ORD: state_in = S_OCHK;
         S_OCHK: begin
            cnt_in   = '0;
            state_in = (off_rd == '0) ? S_CPY : S_MAC;
         end
         S_CPY: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == RING_AW'(COPY_WORDS)) begin
               cnt_in   = '0;
               state_in = S_MAC;
            end
         end
         S_MAC: begin
            issue  = 1'b1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == RING_AW'(BANDS - 1)) begin
               state_in = S_MDRN;
            end
         end
         S_MDRN: begin
            if (drained) begin
               if (row_ff == 4'(ROWS - 1)) begin
                  samp_in  = '0;
                  state_in = S_WRA;
               end else begin
                  row_in   = row_ff + 1'b1;
                  state_in = S_ORD;
               end
            end
         end
         S_WRA: state_in = S_WRB;
         S_WRB: state_in = S_WGB;
         S_WGB: begin
            cnt_in   = '0;
            state_in = S_WMAC;
         end
         S_WMAC: begin
            issue  = 1'b1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == RING_AW'(TAPS - 1)) begin
               state_in = S_WDRN;
            end
         end
         S_WDRN: begin
            if (drained) begin
               state_in = S_WOUT;
            end
         end
         S_WOUT: begin
            if (rsp_load) begin
               samp_in  = samp_ff + 1'b1;
               state_in = (samp_ff == 3'(BANDS - 1)) ? S_IDLE : S_WRA;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // scale and clip the window sum
   always_comb begin
      scaled = acc_ff[SHIFT +: WORD_W];
      if (scaled > PCM_MAX) begin
         clipped = PCM_MAX[PCM_W-1:0];
      end else if (scaled < PCM_MIN) begin
         clipped = PCM_MIN[PCM_W-1:0];
      end else begin
         clipped = scaled[PCM_W-1:0];
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_CLR;
         cnt_ff     <= '0;
         s1_vld_ff  <= 1'b0;
         p_vld_ff   <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         cnt_ff    <= cnt_in;
         s1_vld_ff <= issue;
         p_vld_ff  <= s1_vld_ff;
         if (rsp_load) begin
            rsp_vld_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_vld_ff <= 1'b0;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      row_ff    <= row_in;
      samp_ff   <= samp_in;
      s1_idx_ff <= cnt_ff[3:0];
      prod_ff   <= mul_p[ACC_W-1:0];
      if (req_acc) begin
         ch_ff     <= req.channel;
         sub_ff[0] <= req.sub0;
         sub_ff[1] <= req.sub1;
         sub_ff[2] <= req.sub2;
         sub_ff[3] <= req.sub3;
         sub_ff[4] <= req.sub4;
         sub_ff[5] <= req.sub5;
         sub_ff[6] <= req.sub6;
         sub_ff[7] <= req.sub7;
      end
      if (state_ff == S_OCHK) begin
         off_new_ff <= off_next;
      end
      if (state_ff == S_WRB) begin
         a_ff <= off_rd;
      end
      if (state_ff == S_WGB) begin
         b_ff <= off_rd + 1'b1;
      end
      if (state_ff == S_OCHK || state_ff == S_WGB) begin
         acc_ff <= '0;
      end else if (p_vld_ff) begin
         acc_ff <= acc_ff + prod_ff;
      end
      if (rsp_load) begin
         pcm_ff  <= clipped;
         idx_ff  <= samp_ff;
         last_ff <= (samp_ff == 3'(BANDS - 1));
      end
   end

   assign rsp.valid        = rsp_vld_ff;
   assign rsp.pcm_sample   = pcm_ff;
   assign rsp.sample_index = idx_ff;
   assign rsp.last         = last_ff;

endmodule

@@ rtl/sbs8_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbs8_checker
// Port-level checks of the synthesis filterbank, bound to the top level.
// ----------------------------------------------------------------------------
module sbs8_checker import sbs8_pkg::*; (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_ready,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input logic signed [PCM_W-1:0] rsp_pcm_sample,
   input logic [2:0]              rsp_sample_index,
   input logic                    rsp_last
);

   // a stalled response holds its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pcm_sample)
         && $stable(rsp_sample_index) && $stable(rsp_last))
      else $error("stalled response changed");

   // last marks exactly the eighth sample
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last == (rsp_sample_index == 3'(BANDS - 1))))
      else $error("last flag mismatch");

   // clipping never yields the most negative code
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_pcm_sample != -16'sd32768))
      else $error("sample outside clip range");

   // one request at a time
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

endmodule

bind subband_synthesis_8_core sbs8_checker u_sbs8_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req.valid),
   .req_ready        (req.ready),
   .rsp_valid        (rsp.valid),
   .rsp_ready        (rsp.ready),
   .rsp_pcm_sample   (rsp.pcm_sample),
   .rsp_sample_index (rsp.sample_index),
   .rsp_last         (rsp.last)
);
